// ===== rtl/bclk_pkg.sv =====
package bclk_pkg;

  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned PHASE_W    = 8;
  localparam int unsigned SEC_W      = 6;
  localparam int unsigned MIN_W      = 6;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned BRIGHT_W   = 2;
  localparam int unsigned PINS_W     = 3;

  localparam int unsigned DIV_STEPS  = PHASE_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd23;
  localparam logic [MIN_W-1:0]    MIN_RESET    = 6'd30;
  localparam logic [HOUR_W-1:0]   HOUR_RESET   = 5'd7;
  localparam logic [PINS_W-1:0]   PINS_RESET   = 3'b111;

  localparam logic [SEC_W-1:0]    SEC_LAST     = 6'd59;
  localparam logic [MIN_W-1:0]    MIN_LAST     = 6'd59;
  localparam logic [HOUR_W-1:0]   HOUR_LAST    = 5'd23;

  localparam logic [BRIGHT_W-1:0] BRIGHT_FULL  = 2'd3;

  localparam logic [MODE_W-1:0]   MODE_BRIGHT  = 2'd0;
  localparam logic [MODE_W-1:0]   MODE_HOUR    = 2'd1;
  localparam logic [MODE_W-1:0]   MODE_MINUTE  = 2'd2;

  localparam int unsigned PIN_DOWN = 0;
  localparam int unsigned PIN_UP   = 1;
  localparam int unsigned PIN_MODE = 2;

  typedef enum logic [1:0] {
    REQ_SECOND = 2'd0,
    REQ_FAST   = 2'd1,
    REQ_PINS   = 2'd2
  } req_kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/binary_clock_led_controller.sv =====
// Binary LED clock: each beat on the input carries a second tick, a fast PWM tick or a
// button pin change, and produces exactly one result beat with the LED patterns and the
// current time, mode and brightness. The result is registered and appears in the cycle
// after its input beat is taken. With the result side never stalling and no period write
// under way, one beat is accepted per clock cycle; the input is stalled while a result
// waits, and writing pwm_period stalls it while a restoring divider (one bit per cycle,
// eight steps) reduces the PWM phase modulo the new period.
module binary_clock_led_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bclk_pkg::PERIOD_W-1:0]      cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_req_type,
  input  logic [bclk_pkg::PINS_W-1:0]        in_pin_levels,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bclk_pkg::MIN_W-1:0]         out_minute_leds,
  output logic [bclk_pkg::HOUR_W-1:0]        out_hour_leds,
  output logic                               out_half_hz_out,
  output logic [bclk_pkg::HOUR_W-1:0]        out_cur_hour,
  output logic [bclk_pkg::MIN_W-1:0]         out_cur_minute,
  output logic [bclk_pkg::MODE_W-1:0]        out_adjust_mode_out,
  output logic [bclk_pkg::BRIGHT_W-1:0]      out_brightness_out
);

  logic [bclk_pkg::PERIOD_W-1:0] period_r;
  logic [bclk_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [bclk_pkg::PHASE_W-1:0]  red_r, red_nxt;
  logic [bclk_pkg::SEC_W-1:0]    sec_r, sec_nxt;
  logic [bclk_pkg::MIN_W-1:0]    min_r, min_nxt;
  logic [bclk_pkg::HOUR_W-1:0]   hour_r, hour_nxt;
  logic [bclk_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic [bclk_pkg::BRIGHT_W-1:0] bright_r, bright_nxt;
  logic [bclk_pkg::PINS_W-1:0]   pins_r, pins_nxt;
  logic                          press_r, press_nxt;
  logic [bclk_pkg::MIN_W-1:0]    mpat_r, mpat_nxt;
  logic [bclk_pkg::HOUR_W-1:0]   hpat_r, hpat_nxt;
  logic                          half_r, half_nxt;
  logic                          out_valid_r;

  logic [bclk_pkg::PERIOD_W:0]   period_full;
  logic [bclk_pkg::PHASE_W:0]    phase_inc;
  logic [bclk_pkg::PINS_W-1:0]   changed;
  logic [bclk_pkg::PHASE_W-1:0]  lit_phase;
  logic                          do_refresh;
  logic                          lit;
  logic [bclk_pkg::PHASE_W-1:0]  thresh;
  logic [bclk_pkg::HOUR_W-1:0]   hour_dn;
  logic [bclk_pkg::MIN_W-1:0]    min_dn;
  logic [bclk_pkg::BRIGHT_W-1:0] bright_dn;
  logic                          accept;

  bclk_pkg::div_status_t         div_status;
  logic [bclk_pkg::PHASE_W-1:0]  div_rem;
  logic [bclk_pkg::PHASE_W:0]    div_divisor;

  function automatic logic [bclk_pkg::MIN_W-1:0] reverse6(input logic [bclk_pkg::MIN_W-1:0] v);
    logic [bclk_pkg::MIN_W-1:0] r;
    for (int i = 0; i < bclk_pkg::MIN_W; i++) begin
      r[bclk_pkg::MIN_W-1-i] = v[i];
    end
    return r;
  endfunction

  assign div_divisor = {(cfg_wdata == '0), cfg_wdata};

  bclk_phase_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cfg_we),
    .dividend  (phase_r),
    .divisor   (div_divisor),
    .status    (div_status),
    .remainder (div_rem)
  );

  assign in_stall  = div_status.busy | div_status.done | (out_valid_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;

  assign period_full = {(period_r == '0), period_r};
  assign phase_inc   = {1'b0, red_r} + 1'b1;
  assign changed     = in_pin_levels ^ pins_r;

  always_comb begin
    phase_nxt  = phase_r;
    red_nxt    = red_r;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hour_nxt   = hour_r;
    mode_nxt   = mode_r;
    bright_nxt = bright_r;
    pins_nxt   = pins_r;
    press_nxt  = press_r;
    half_nxt   = half_r;
    do_refresh = 1'b0;
    lit_phase  = phase_r;
    hour_dn    = hour_r;
    min_dn     = min_r;
    bright_dn  = bright_r;
    unique case (bclk_pkg::req_kind_t'(in_req_type))
      bclk_pkg::REQ_SECOND: begin
        half_nxt   = ~half_r;
        do_refresh = 1'b1;
        if (sec_r == bclk_pkg::SEC_LAST) begin
          sec_nxt = '0;
          if (min_r == bclk_pkg::MIN_LAST) begin
            min_nxt  = '0;
            hour_nxt = (hour_r == bclk_pkg::HOUR_LAST) ? '0 : hour_r + 1'b1;
          end else begin
            min_nxt = min_r + 1'b1;
          end
        end else begin
          sec_nxt = sec_r + 1'b1;
        end
      end
      bclk_pkg::REQ_FAST: begin
        if (phase_inc == period_full) begin
          phase_nxt = '0;
        end else begin
          phase_nxt = phase_inc[bclk_pkg::PHASE_W-1:0];
        end
        red_nxt    = phase_nxt;
        lit_phase  = phase_nxt;
        do_refresh = 1'b1;
      end
      bclk_pkg::REQ_PINS: begin
        pins_nxt  = in_pin_levels;
        press_nxt = ~press_r;
        if (press_r) begin
          if (changed[bclk_pkg::PIN_DOWN]) begin
            if (mode_r == bclk_pkg::MODE_BRIGHT) begin
              bright_dn = bright_r - 1'b1;
            end else if (mode_r == bclk_pkg::MODE_HOUR) begin
              hour_dn = (hour_r == '0) ? bclk_pkg::HOUR_LAST : hour_r - 1'b1;
            end else if (mode_r == bclk_pkg::MODE_MINUTE) begin
              min_dn = (min_r == '0) ? bclk_pkg::MIN_LAST : min_r - 1'b1;
            end
          end
          bright_nxt = bright_dn;
          hour_nxt   = hour_dn;
          min_nxt    = min_dn;
          if (changed[bclk_pkg::PIN_UP]) begin
            if (mode_r == bclk_pkg::MODE_BRIGHT) begin
              bright_nxt = bright_dn + 1'b1;
            end else if (mode_r == bclk_pkg::MODE_HOUR) begin
              hour_nxt = (hour_dn == bclk_pkg::HOUR_LAST) ? '0 : hour_dn + 1'b1;
            end else if (mode_r == bclk_pkg::MODE_MINUTE) begin
              min_nxt = (min_dn == bclk_pkg::MIN_LAST) ? '0 : min_dn + 1'b1;
            end
          end
          if (changed[bclk_pkg::PIN_MODE]) begin
            mode_nxt = (mode_r == bclk_pkg::MODE_MINUTE) ? bclk_pkg::MODE_BRIGHT
                                                         : mode_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign thresh = {{(bclk_pkg::PHASE_W-bclk_pkg::BRIGHT_W){1'b0}}, bright_r} * 8'd5 - 8'd4;

  always_comb begin
    lit      = (bright_r != '0) && ((bright_r == bclk_pkg::BRIGHT_FULL) || (lit_phase < thresh));
    mpat_nxt = mpat_r;
    hpat_nxt = hpat_r;
    if (do_refresh) begin
      if (lit) begin
        mpat_nxt = reverse6(min_nxt);
        hpat_nxt = hour_nxt;
      end else begin
        if (mode_r != bclk_pkg::MODE_HOUR) begin
          mpat_nxt = '0;
        end
        if (mode_r != bclk_pkg::MODE_MINUTE) begin
          hpat_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= bclk_pkg::PERIOD_RESET;
      phase_r     <= '0;
      red_r       <= '0;
      sec_r       <= '0;
      min_r       <= bclk_pkg::MIN_RESET;
      hour_r      <= bclk_pkg::HOUR_RESET;
      mode_r      <= bclk_pkg::MODE_BRIGHT;
      bright_r    <= '0;
      pins_r      <= bclk_pkg::PINS_RESET;
      press_r     <= 1'b0;
      mpat_r      <= '0;
      hpat_r      <= '0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      if (div_status.done) begin
        red_r <= div_rem;
      end
      if (accept) begin
        phase_r  <= phase_nxt;
        red_r    <= red_nxt;
        sec_r    <= sec_nxt;
        min_r    <= min_nxt;
        hour_r   <= hour_nxt;
        mode_r   <= mode_nxt;
        bright_r <= bright_nxt;
        pins_r   <= pins_nxt;
        press_r  <= press_nxt;
        mpat_r   <= mpat_nxt;
        hpat_r   <= hpat_nxt;
        half_r   <= half_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_minute_leds     <= mpat_nxt;
      out_hour_leds       <= hpat_nxt;
      out_half_hz_out     <= half_nxt;
      out_cur_hour        <= hour_nxt;
      out_cur_minute      <= min_nxt;
      out_adjust_mode_out <= mode_nxt;
      out_brightness_out  <= bright_nxt;
    end
  end

  a_stall_while_reducing: assert property (@(posedge clk) disable iff (!rst_n)
    (div_status.busy || div_status.done) |-> in_stall)
    else $error("input taken while the phase is being reduced");

  a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hour_r <= bclk_pkg::HOUR_LAST) && (min_r <= bclk_pkg::MIN_LAST) &&
    (sec_r <= bclk_pkg::SEC_LAST))
    else $error("time of day out of range");

  a_phase_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    (!div_status.busy && !div_status.done && !$past(cfg_we)) |->
    ({1'b0, red_r} < period_full))
    else $error("reduced PWM phase not below the period");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_mode_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= bclk_pkg::MODE_MINUTE)
    else $error("adjust mode reached an unused value");

endmodule

// ===== rtl/bclk_phase_div.sv =====
module bclk_phase_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [bclk_pkg::PHASE_W-1:0]      dividend,
  input  logic [bclk_pkg::PHASE_W:0]        divisor,
  output bclk_pkg::div_status_t             status,
  output logic [bclk_pkg::PHASE_W-1:0]      remainder
);

  logic [bclk_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           done_r, done_nxt;
  logic [bclk_pkg::PHASE_W-1:0]   rem_r, rem_nxt;
  logic [bclk_pkg::PHASE_W-1:0]   quo_r, quo_nxt;
  logic [bclk_pkg::PHASE_W:0]     div_r, div_nxt;
  logic [bclk_pkg::PHASE_W:0]     trial;
  logic [bclk_pkg::PHASE_W:0]     diff;

  assign trial = {rem_r, quo_r[bclk_pkg::PHASE_W-1]};
  assign diff  = trial - div_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      cnt_nxt = bclk_pkg::DIV_CNT_W'(bclk_pkg::DIV_STEPS);
      rem_nxt = '0;
      quo_nxt = dividend;
      div_nxt = divisor;
    end else if (cnt_r != '0) begin
      if (trial >= div_r) begin
        rem_nxt = diff[bclk_pkg::PHASE_W-1:0];
      end else begin
        rem_nxt = trial[bclk_pkg::PHASE_W-1:0];
      end
      quo_nxt = {quo_r[bclk_pkg::PHASE_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == bclk_pkg::DIV_CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign status.busy = (cnt_r != '0);
  assign status.done = done_r;
  assign remainder   = rem_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(cnt_r) == bclk_pkg::DIV_CNT_W'(1))
    else $error("remainder ready without a finished reduction");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < div_r))
    else $error("remainder not below divisor");

  a_busy_never_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(status.busy && done_r && !$past(start)))
    else $error("reduction busy and done together");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                  REQ_UNUSED   = 2'd3;
  localparam logic [bclk_pkg::PINS_W-1:0] PINS_IDLE    = bclk_pkg::PINS_RESET;
  localparam logic [bclk_pkg::PINS_W-1:0] BTN_DOWN     = 3'b001 << bclk_pkg::PIN_DOWN;
  localparam logic [bclk_pkg::PINS_W-1:0] BTN_UP       = 3'b001 << bclk_pkg::PIN_UP;
  localparam logic [bclk_pkg::PINS_W-1:0] BTN_MODE     = 3'b001 << bclk_pkg::PIN_MODE;
  localparam int                          CYCLE_LIMIT  = 200000;
  localparam int                          DRAIN_CYCLES = 16;
  localparam int                          RANDOM_ITEMS = 750;
  localparam int                          NUM_PHASES   = 6;
  localparam int                          SIDE_IN      = 0;
  localparam int                          SIDE_OUT     = 1;

  typedef struct packed {
    logic [bclk_pkg::MIN_W-1:0]    minute_leds;
    logic [bclk_pkg::HOUR_W-1:0]   hour_leds;
    logic                          half_hz;
    logic [bclk_pkg::HOUR_W-1:0]   hour;
    logic [bclk_pkg::MIN_W-1:0]    minute;
    logic [bclk_pkg::MODE_W-1:0]   mode;
    logic [bclk_pkg::BRIGHT_W-1:0] bright;
  } clock_view_t;

  class clock_scoreboard;
    logic [bclk_pkg::PERIOD_W-1:0] period;
    logic [bclk_pkg::PHASE_W-1:0]  phase;
    logic [bclk_pkg::SEC_W-1:0]    sec;
    logic [bclk_pkg::MIN_W-1:0]    min;
    logic [bclk_pkg::HOUR_W-1:0]   hr;
    logic [bclk_pkg::MODE_W-1:0]   mode;
    logic [bclk_pkg::BRIGHT_W-1:0] bright;
    logic [bclk_pkg::PINS_W-1:0]   prev_pins;
    logic                          press;
    logic [bclk_pkg::MIN_W-1:0]    min_pat;
    logic [bclk_pkg::HOUR_W-1:0]   hr_pat;
    logic                          half;
    clock_view_t                   pending[$];
    int                            mismatches;

    function new();
      period     = bclk_pkg::PERIOD_RESET;
      phase      = '0;
      sec        = '0;
      min        = bclk_pkg::MIN_RESET;
      hr         = bclk_pkg::HOUR_RESET;
      mode       = bclk_pkg::MODE_BRIGHT;
      bright     = '0;
      prev_pins  = bclk_pkg::PINS_RESET;
      press      = 1'b0;
      min_pat    = '0;
      hr_pat     = '0;
      half       = 1'b0;
      mismatches = 0;
    endfunction

    function void set_period(logic [bclk_pkg::PERIOD_W-1:0] value);
      period = value;
    endfunction

    function void refresh_patterns();
      logic lit;
      lit = (bright != 0) &&
            (bright == bclk_pkg::BRIGHT_FULL || int'(phase) < int'(bright) * 5 - 4);
      if (lit) begin
        min_pat = {<<{min}};
        hr_pat  = hr;
      end else begin
        if (mode != bclk_pkg::MODE_HOUR) min_pat = '0;
        if (mode != bclk_pkg::MODE_MINUTE) hr_pat = '0;
      end
    endfunction

    function void tick_second();
      if (sec == bclk_pkg::SEC_LAST) begin
        sec = '0;
        if (min == bclk_pkg::MIN_LAST) begin
          min = '0;
          hr  = (hr == bclk_pkg::HOUR_LAST) ? '0 : hr + 1'b1;
        end else begin
          min = min + 1'b1;
        end
      end else begin
        sec = sec + 1'b1;
      end
      half = ~half;
      refresh_patterns();
    endfunction

    function void tick_fast();
      int span;
      span  = (period == 0) ? 256 : int'(period);
      phase = bclk_pkg::PHASE_W'((int'(phase) + 1) % span);
      refresh_patterns();
    endfunction

    function void apply_pins(logic [bclk_pkg::PINS_W-1:0] pins);
      logic [bclk_pkg::PINS_W-1:0] changed;
      logic [bclk_pkg::MODE_W-1:0] held;
      changed   = pins ^ prev_pins;
      held      = mode;
      prev_pins = pins;
      press     = ~press;
      if (press) return;
      if (changed[bclk_pkg::PIN_DOWN]) begin
        case (held)
          bclk_pkg::MODE_BRIGHT: bright = bright - 1'b1;
          bclk_pkg::MODE_HOUR:   hr = (hr == 0) ? bclk_pkg::HOUR_LAST : hr - 1'b1;
          bclk_pkg::MODE_MINUTE: min = (min == 0) ? bclk_pkg::MIN_LAST : min - 1'b1;
          default: ;
        endcase
      end
      if (changed[bclk_pkg::PIN_UP]) begin
        case (held)
          bclk_pkg::MODE_BRIGHT: bright = bright + 1'b1;
          bclk_pkg::MODE_HOUR:   hr = (hr == bclk_pkg::HOUR_LAST) ? '0 : hr + 1'b1;
          bclk_pkg::MODE_MINUTE: min = (min == bclk_pkg::MIN_LAST) ? '0 : min + 1'b1;
          default: ;
        endcase
      end
      if (changed[bclk_pkg::PIN_MODE]) begin
        mode = (held == bclk_pkg::MODE_MINUTE) ? bclk_pkg::MODE_BRIGHT : held + 1'b1;
      end
    endfunction

    function void note_input(logic [1:0] kind, logic [bclk_pkg::PINS_W-1:0] pins);
      clock_view_t v;
      case (kind)
        bclk_pkg::REQ_SECOND: tick_second();
        bclk_pkg::REQ_FAST:   tick_fast();
        bclk_pkg::REQ_PINS:   apply_pins(pins);
        default: ;
      endcase
      v = {min_pat, hr_pat, half, hr, min, mode, bright};
      pending.push_back(v);
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) begin
        report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
      end
    endtask

    task check_result(clock_view_t got);
      clock_view_t want;
      if (pending.size() == 0) begin
        report_mismatch("result beat arrived with no prediction pending");
        return;
      end
      want = pending.pop_front();
      compare_field("minute_leds", got.minute_leds, want.minute_leds);
      compare_field("hour_leds", got.hour_leds, want.hour_leds);
      compare_field("half_hz_out", got.half_hz, want.half_hz);
      compare_field("cur_hour", got.hour, want.hour);
      compare_field("cur_minute", got.minute, want.minute);
      compare_field("adjust_mode_out", got.mode, want.mode);
      compare_field("brightness_out", got.bright, want.bright);
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [bclk_pkg::PERIOD_W-1:0] cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    in_req_type;
  logic [bclk_pkg::PINS_W-1:0]   in_pin_levels;
  logic                          out_valid;
  logic                          out_stall;
  logic [bclk_pkg::MIN_W-1:0]    out_minute_leds;
  logic [bclk_pkg::HOUR_W-1:0]   out_hour_leds;
  logic                          out_half_hz_out;
  logic [bclk_pkg::HOUR_W-1:0]   out_cur_hour;
  logic [bclk_pkg::MIN_W-1:0]    out_cur_minute;
  logic [bclk_pkg::MODE_W-1:0]   out_adjust_mode_out;
  logic [bclk_pkg::BRIGHT_W-1:0] out_brightness_out;

  clock_scoreboard sb;
  int              calm_left[2];

  binary_clock_led_controller uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_pin_levels       (in_pin_levels),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_minute_leds     (out_minute_leds),
    .out_hour_leds       (out_hour_leds),
    .out_half_hz_out     (out_half_hz_out),
    .out_cur_hour        (out_cur_hour),
    .out_cur_minute      (out_cur_minute),
    .out_adjust_mode_out (out_adjust_mode_out),
    .out_brightness_out  (out_brightness_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Each side occasionally enters a calm stretch in which beats flow back to back.
  function automatic int draw_wait(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm_left[side] = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  task automatic push_beat(logic [1:0] kind, logic [bclk_pkg::PINS_W-1:0] pins);
    int gap;
    gap = draw_wait(SIDE_IN);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_pin_levels <= pins;
    do @(posedge clk); while (in_stall);
    sb.note_input(kind, pins);
  endtask

  task automatic press_button(logic [bclk_pkg::PINS_W-1:0] mask);
    push_beat(bclk_pkg::REQ_PINS, PINS_IDLE ^ mask);
    push_beat(bclk_pkg::REQ_PINS, PINS_IDLE);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_period(logic [bclk_pkg::PERIOD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_period(value);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(int count);
    int done;
    int pick;
    int len;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        len = $urandom_range(1, 40);
        repeat (len) push_beat(bclk_pkg::REQ_FAST, bclk_pkg::PINS_W'($urandom_range(0, 7)));
        done += len;
      end else if (pick < 50) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 10);
        repeat (len) push_beat(bclk_pkg::REQ_SECOND, bclk_pkg::PINS_W'($urandom_range(0, 7)));
        done += len;
      end else if (pick < 90) begin
        press_button(bclk_pkg::PINS_W'($urandom_range(1, 7)));
        done += 2;
      end else if (pick < 95) begin
        push_beat(bclk_pkg::REQ_PINS, bclk_pkg::PINS_W'($urandom_range(0, 7)));
        done++;
      end else begin
        push_beat(REQ_UNUSED, bclk_pkg::PINS_W'($urandom_range(0, 7)));
        done++;
      end
    end
  endtask

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL binary_clock_led_controller");
    $finish;
  end

  initial begin
    clock_view_t seen;
    int          w;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      w = draw_wait(SIDE_OUT);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      seen = {out_minute_leds, out_hour_leds, out_half_hz_out, out_cur_hour,
              out_cur_minute, out_adjust_mode_out, out_brightness_out};
      sb.check_result(seen);
    end
  end

  initial begin
    logic [bclk_pkg::PERIOD_W-1:0] periods[NUM_PHASES];
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_req_type   <= bclk_pkg::REQ_SECOND;
    in_pin_levels <= PINS_IDLE;
    calm_left[SIDE_IN]  = 0;
    calm_left[SIDE_OUT] = 0;
    sb = new();
    periods = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd100, 8'd23};
    periods[4] = bclk_pkg::PERIOD_W'($urandom_range(2, 254));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The unused kind must leave everything alone, even with all pins low.
    push_beat(REQ_UNUSED, 3'b000);
    push_beat(bclk_pkg::REQ_SECOND, PINS_IDLE);
    push_beat(bclk_pkg::REQ_FAST, PINS_IDLE);
    press_button(BTN_DOWN);
    push_beat(bclk_pkg::REQ_FAST, PINS_IDLE);
    press_button(BTN_UP);
    press_button(BTN_UP);
    push_beat(bclk_pkg::REQ_FAST, PINS_IDLE);
    push_beat(bclk_pkg::REQ_SECOND, PINS_IDLE);
    press_button(BTN_MODE);
    push_beat(bclk_pkg::REQ_SECOND, PINS_IDLE);
    press_button(BTN_DOWN);
    press_button(BTN_MODE);
    push_beat(bclk_pkg::REQ_SECOND, PINS_IDLE);
    press_button(BTN_DOWN | BTN_UP | BTN_MODE);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_period(periods[p]);
      run_random(RANDOM_ITEMS / NUM_PHASES);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS binary_clock_led_controller");
    end else begin
      $display("FAIL binary_clock_led_controller");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/bclk_pkg.sv
rtl/bclk_phase_div.sv
rtl/binary_clock_led_controller.sv
tb/sv/tb.sv
